// File: sv/mmrms_pkg.sv
// shared constants for the multichannel moving rms block
`timescale 1ns / 1ps

package mmrms_pkg;

  // sizing of the block
  localparam int WINDOW      = 512;
  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 16;

  // fixed port field widths
  localparam int CH_IN_W     = 3;
  localparam int SAMPLE_IN_W = 16;
  localparam int RMS_W       = 16;

  // window and channel count are powers of two, so the means are plain shifts
  localparam int WIN_LOG2  = $clog2(WINDOW);
  localparam int POS_W     = WIN_LOG2;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W    = $clog2(CHANNELS * WINDOW);
  localparam int SQ_W      = 2 * SAMPLE_BITS;
  localparam int SUM_W     = 2 * SAMPLE_BITS - 1 + WIN_LOG2;
  localparam int TOT_W     = SUM_W + CH_W;
  localparam int TOT_SHIFT = $clog2(WINDOW * CHANNELS);
  localparam int MEAN_W    = 2 * SAMPLE_BITS - 1;
  localparam int ROOT_W    = SAMPLE_BITS;
  localparam int OP_W      = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int ROOT_XW   = (ROOT_W > RMS_W) ? ROOT_W : RMS_W + 1;
  localparam int BIT_CNT_W = $clog2(SAMPLE_BITS);

endpackage

// File: sv/mmrms_if.sv
// request and result channel interfaces of the moving rms block
`timescale 1ns / 1ps

interface mmrms_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mmrms_pkg::CH_IN_W-1:0]         channel;
  logic signed [mmrms_pkg::SAMPLE_IN_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface mmrms_out_if;
  logic                          valid;
  logic                          ready;
  logic [mmrms_pkg::CH_IN_W-1:0] channel_out;
  logic [mmrms_pkg::RMS_W-1:0]   channel_rms;
  logic [mmrms_pkg::RMS_W-1:0]   overall_rms;

  modport source (output valid, output channel_out, output channel_rms, output overall_rms,
                  input ready);
  modport sink (input valid, input channel_out, input channel_rms, input overall_rms,
                output ready);
endinterface

// File: sv/multichannel_moving_rms.sv
// multichannel moving window rms with bit-serial squarers and square roots
//
// in_if carries one request: a channel number and a signed sample. the sample
// replaces the oldest entry of that channel's window and the running sum of
// squares is updated. out_if returns one result per request: the channel, the
// floor rms over that channel's window and the floor rms over all channels.
// a request for a channel beyond the configured count changes nothing and
// returns a channel rms of zero.
// one request is worked at a time: the next one is taken only once the result of
// the last is stored in the output register. the squarers are bit-serial, one
// multiplier bit per cycle, as are the square root units, one root bit per cycle.
// reset empties all windows at once: a per-channel fill flag makes slots that
// were never written read as zero, so there is no clearing pass.
// the result sits in an output register until taken; a stalled receiver holds
// back only the next result, and in_if.ready stays low until it can be stored.
`timescale 1ns / 1ps

module multichannel_moving_rms (
  input  logic           clk,
  input  logic           rst_n,
  mmrms_in_if.sink       in_if,
  mmrms_out_if.source    out_if
);
  import mmrms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_MULT,
    S_UPDATE,
    S_SQRT,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [CH_IN_W-1:0]      chan_r;
  logic [CH_W-1:0]         ch_idx_r;
  logic                    ch_ok_r;
  logic [SAMPLE_BITS-1:0]  sample_r;
  logic [ADDR_W-1:0]       addr_r;
  logic [SAMPLE_BITS-1:0]  rd_data_r;
  logic [BIT_CNT_W-1:0]    bit_cnt_r;

  logic [POS_W-1:0]        pos_r    [CHANNELS];
  logic                    filled_r [CHANNELS];
  logic [SUM_W-1:0]        sum_r    [CHANNELS];
  logic [TOT_W-1:0]        total_r;

  logic [SAMPLE_BITS-1:0]  win_mem [CHANNELS * WINDOW];

  // squarers: index 0 for the evicted sample, 1 for the new one
  logic [SAMPLE_BITS-1:0]  mcand_r [2];
  logic [SQ_W-1:0]         prod_r  [2];
  logic [SQ_W-1:0]         prod_nxt [2];

  // square roots: index 0 for the channel, 1 for the overall mean
  logic [OP_W-1:0]         sq_op_r   [2];
  logic [REM_W-1:0]        sq_rem_r  [2];
  logic [ROOT_W-1:0]       sq_root_r [2];
  logic [OP_W-1:0]         sq_op_nxt   [2];
  logic [REM_W-1:0]        sq_rem_nxt  [2];
  logic [ROOT_W-1:0]       sq_root_nxt [2];

  logic                    out_valid_r;
  logic [CH_IN_W-1:0]      out_chan_r;
  logic [RMS_W-1:0]        out_ch_rms_r;
  logic [RMS_W-1:0]        out_all_rms_r;

  logic                    in_fire;
  logic [CH_W-1:0]         in_ch_idx;
  logic [SAMPLE_BITS-1:0]  old_sample;
  logic [SAMPLE_BITS-1:0]  mag_old;
  logic [SAMPLE_BITS-1:0]  mag_new;
  logic [POS_W-1:0]        pos_cur;
  logic [POS_W-1:0]        pos_nxt;
  logic [SUM_W-1:0]        sum_nxt;
  logic [TOT_W-1:0]        total_nxt;
  logic                    bit_last;

  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
    return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
  endfunction

  function automatic logic [RMS_W-1:0] sat_rms(input logic [ROOT_W-1:0] r);
    logic [ROOT_XW-1:0] x;
    x = ROOT_XW'(r);
    return (x > ROOT_XW'({RMS_W{1'b1}})) ? {RMS_W{1'b1}} : x[RMS_W-1:0];
  endfunction

  assign in_fire   = in_if.valid && in_if.ready;
  assign in_ch_idx = CH_W'(in_if.channel);
  assign bit_last  = (bit_cnt_r == BIT_CNT_W'(SAMPLE_BITS - 1));

  // a slot not yet written since reset holds zero
  assign old_sample = filled_r[ch_idx_r] ? rd_data_r : '0;
  assign mag_old    = magnitude(old_sample);
  assign mag_new    = magnitude(sample_r);

  assign pos_cur = pos_r[ch_idx_r];
  assign pos_nxt = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + 1'b1;

  assign sum_nxt   = sum_r[ch_idx_r] - SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]);
  assign total_nxt = ch_ok_r ? (total_r - TOT_W'(prod_r[0]) + TOT_W'(prod_r[1])) : total_r;

  // one shift-add step per squarer, one root digit per square root unit
  always_comb begin
    logic [SAMPLE_BITS:0] add;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 ge;
    for (int u = 0; u < 2; u++) begin
      add = {1'b0, prod_r[u][SQ_W-1:SAMPLE_BITS]}
          + (prod_r[u][0] ? {1'b0, mcand_r[u]} : '0);
      prod_nxt[u] = {add, prod_r[u][SAMPLE_BITS-1:1]};

      rem_sh = {sq_rem_r[u][REM_W-3:0], sq_op_r[u][OP_W-1 -: 2]};
      trial  = {sq_root_r[u], 2'b01};
      ge     = (rem_sh >= trial);
      sq_rem_nxt[u]  = ge ? (rem_sh - trial) : rem_sh;
      sq_root_nxt[u] = {sq_root_r[u][ROOT_W-2:0], ge};
      sq_op_nxt[u]   = {sq_op_r[u][OP_W-3:0], 2'b00};
    end
  end

  // sample window memory
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_data_r <= win_mem[addr_r];
    end
    if (state_r == S_LOAD && ch_ok_r) begin
      win_mem[addr_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c]    <= '0;
        filled_r[c] <= 1'b0;
        sum_r[c]    <= '0;
      end
    end else begin
      // a new result may replace the one taken in the same cycle
      if (state_r == S_DONE && (!out_valid_r || out_if.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            chan_r   <= in_if.channel;
            ch_idx_r <= in_ch_idx;
            ch_ok_r  <= (32'(in_if.channel) < 32'(CHANNELS));
            sample_r <= in_if.sample[SAMPLE_BITS-1:0];
            addr_r   <= ADDR_W'(ADDR_W'(in_ch_idx) * ADDR_W'(WINDOW))
                      + ADDR_W'(pos_r[in_ch_idx]);
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          mcand_r[0] <= mag_old;
          mcand_r[1] <= mag_new;
          prod_r[0]  <= SQ_W'(mag_old);
          prod_r[1]  <= SQ_W'(mag_new);
          bit_cnt_r  <= '0;
          if (ch_ok_r) begin
            pos_r[ch_idx_r] <= pos_nxt;
            if (pos_nxt == '0) begin
              filled_r[ch_idx_r] <= 1'b1;
            end
          end
          state_r <= S_MULT;
        end
        S_MULT: begin
          prod_r[0] <= prod_nxt[0];
          prod_r[1] <= prod_nxt[1];
          bit_cnt_r <= bit_cnt_r + 1'b1;
          if (bit_last) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (ch_ok_r) begin
            sum_r[ch_idx_r] <= sum_nxt;
            sq_op_r[0]      <= OP_W'(sum_nxt[WIN_LOG2 +: MEAN_W]);
          end else begin
            sq_op_r[0] <= '0;
          end
          total_r      <= total_nxt;
          sq_op_r[1]   <= OP_W'(total_nxt[TOT_SHIFT +: MEAN_W]);
          sq_rem_r[0]  <= '0;
          sq_rem_r[1]  <= '0;
          sq_root_r[0] <= '0;
          sq_root_r[1] <= '0;
          bit_cnt_r    <= '0;
          state_r      <= S_SQRT;
        end
        S_SQRT: begin
          for (int u = 0; u < 2; u++) begin
            sq_op_r[u]   <= sq_op_nxt[u];
            sq_rem_r[u]  <= sq_rem_nxt[u];
            sq_root_r[u] <= sq_root_nxt[u];
          end
          bit_cnt_r <= bit_cnt_r + 1'b1;
          if (bit_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // wait here only while the previous result is still unclaimed
          if (!out_valid_r || out_if.ready) begin
            out_chan_r    <= chan_r;
            out_ch_rms_r  <= sat_rms(sq_root_r[0]);
            out_all_rms_r <= sat_rms(sq_root_r[1]);
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.channel_out = out_chan_r;
  assign out_if.channel_rms = out_ch_rms_r;
  assign out_if.overall_rms = out_all_rms_r;

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("request taken while a previous one is in flight");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

  a_sum_covers_evicted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) && ch_ok_r |-> (sum_r[ch_idx_r] >= SUM_W'(prod_r[0])))
    else $error("evicted square exceeds the channel sum of squares");
`endif

endmodule
